@@ rtl/age_based_cache_evictor_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the age-based cache evictor
// Shared forms for the concurrent checks of the evictor's checker.
// ----------------------------------------------------------------------------
`ifndef AGE_BASED_CACHE_EVICTOR_DEFINES_SVH
`define AGE_BASED_CACHE_EVICTOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define ABCE_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ABCE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/abce_pkg.sv @@
// ----------------------------------------------------------------------------
// Age-based cache evictor package
// Types, default sizes and fixed field widths shared by the evictor modules.
// ----------------------------------------------------------------------------
package abce_pkg;

  localparam int DEF_ENTRIES     = 1024;
  localparam int DEF_AGE_BITS    = 16;
  localparam int DEF_LENGTH_BITS = 24;

  localparam int OP_W      = 2;
  localparam int ID_W      = 10;
  localparam int LEN_IN_W  = 24;
  localparam int LIMIT_W   = 35;
  localparam int BYTES_O_W = 34;
  localparam int COUNT_O_W = 11;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(64'd1024 * 64'd1024 * 64'd1024);

  typedef enum logic [OP_W-1:0] {
    OP_TOUCH = 2'd0,
    OP_BATCH = 2'd1,
    OP_PURGE = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_TOUCH,
    S_AGE,
    S_MAX,
    S_EVICT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic                 load_needed;
    logic [BYTES_O_W-1:0] bytes_in_use;
    logic [COUNT_O_W-1:0] entries_cached;
    logic [COUNT_O_W-1:0] entries_evicted;
  } result_t;

endpackage

@@ rtl/age_based_cache_evictor.sv @@
// ----------------------------------------------------------------------------
// Age-based cache evictor
// Entry table with per-entry age and cached length, kept within a byte budget
// by purging the oldest entries first.
// ----------------------------------------------------------------------------
// Usage. Input words (opcode, read_id, read_length) arrive on a valid/ready
// channel; each produces exactly one result word (load_needed, bytes_in_use,
// entries_cached, entries_evicted) on a second valid/ready channel. The byte
// budget is to be written through cfg_we/cfg_wdata only while the block is
// idle; the block itself does not enforce this. A touch is a single
// read-modify-write of one table entry: the entry is read on acceptance and,
// in the S_TOUCH state that follows, written back as its result enters the
// output register, and the block then returns to idle. An end-of-batch word
// sweeps the whole table once, then posts its result from S_DONE. A purge
// under budget posts its result from S_DONE without a sweep; otherwise it
// runs one sweep to find the oldest age and one sweep per age level evicted,
// then posts its result. The sweeps are bound by the one read port of the
// table memory. One word is worked on at a time, and the next word may be
// accepted while the previous result still waits in the output register.
// After reset the block clears the table, one entry per cycle, with in_ready
// low; the budget resets to 1 GiB. When the receiver stalls, a finished
// result waits in its state until the output register is free, holding the
// table untouched.
// ----------------------------------------------------------------------------
module age_based_cache_evictor import abce_pkg::*; #(
  parameter int ENTRIES     = DEF_ENTRIES,
  parameter int AGE_BITS    = DEF_AGE_BITS,
  parameter int LENGTH_BITS = DEF_LENGTH_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [LIMIT_W-1:0]   cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [OP_W-1:0]      opcode,
  input  logic [ID_W-1:0]      read_id,
  input  logic [LEN_IN_W-1:0]  read_length,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 load_needed,
  output logic [BYTES_O_W-1:0] bytes_in_use,
  output logic [COUNT_O_W-1:0] entries_cached,
  output logic [COUNT_O_W-1:0] entries_evicted
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int MEM_W = AGE_BITS + LENGTH_BITS;

  logic [LIMIT_W-1:0] memory_limit_bytes;
  logic               out_free;
  logic               res_valid;
  result_t            res;
  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic [MEM_W-1:0]   rd_data;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [MEM_W-1:0]   wr_data;

  // The byte budget register; writes take effect on the next cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      memory_limit_bytes <= LIMIT_RESET;
    end else if (cfg_we) begin
      memory_limit_bytes <= cfg_wdata;
    end
  end

  // The output register frees up in the same cycle its word is taken, so the
  // controller can post a new result back to back with the consumer.
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      load_needed     <= res.load_needed;
      bytes_in_use    <= res.bytes_in_use;
      entries_cached  <= res.entries_cached;
      entries_evicted <= res.entries_evicted;
    end
  end

  abce_ctrl #(
    .ENTRIES     (ENTRIES),
    .AGE_BITS    (AGE_BITS),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .opcode      (opcode),
    .read_id     (read_id),
    .read_length (read_length),
    .limit       (memory_limit_bytes),
    .out_free    (out_free),
    .res_valid   (res_valid),
    .res         (res),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data)
  );

  // Sweeps read one entry ahead of the entry being written back, and a touch
  // is only issued once a sweep has retired, so no access ever overlaps.
  abce_table_mem #(
    .DEPTH (ENTRIES),
    .WIDTH (MEM_W)
  ) u_table (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

endmodule

@@ rtl/abce_table_mem.sv @@
// ----------------------------------------------------------------------------
// Evictor entry table
// Single-port-write, single-port-read synchronous memory holding each
// entry's age and cached length, with registered read data.
// ----------------------------------------------------------------------------
module abce_table_mem import abce_pkg::*; #(
  parameter int DEPTH = DEF_ENTRIES,
  parameter int WIDTH = DEF_AGE_BITS + DEF_LENGTH_BITS
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/abce_ctrl.sv @@
// ----------------------------------------------------------------------------
// Evictor controller
// Sequencer that clears the table after reset, performs touch
// read-modify-writes and sweeps the table for ageing and purging.
// ----------------------------------------------------------------------------
module abce_ctrl import abce_pkg::*; #(
  parameter int ENTRIES     = DEF_ENTRIES,
  parameter int AGE_BITS    = DEF_AGE_BITS,
  parameter int LENGTH_BITS = DEF_LENGTH_BITS,
  localparam int IDX_W      = $clog2(ENTRIES),
  localparam int MEM_W      = AGE_BITS + LENGTH_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [OP_W-1:0]     opcode,
  input  logic [ID_W-1:0]     read_id,
  input  logic [LEN_IN_W-1:0] read_length,
  input  logic [LIMIT_W-1:0]  limit,
  input  logic                out_free,
  output logic                res_valid,
  output result_t             res,
  output logic                rd_en,
  output logic [IDX_W-1:0]    rd_addr,
  input  logic [MEM_W-1:0]    rd_data,
  output logic                wr_en,
  output logic [IDX_W-1:0]    wr_addr,
  output logic [MEM_W-1:0]    wr_data
);

  localparam int PC_W    = $clog2(ENTRIES + 1);
  localparam int BYTES_W = IDX_W + LENGTH_BITS;
  localparam int LIM_CW  = (BYTES_W > LIMIT_W) ? BYTES_W : LIMIT_W;
  localparam int BYT_CW  = (BYTES_W > BYTES_O_W) ? BYTES_W : BYTES_O_W;
  localparam int CNT_CW  = (PC_W > COUNT_O_W) ? PC_W : COUNT_O_W;
  localparam int ID_CW   = (IDX_W + 1 > ID_W) ? IDX_W + 1 : ID_W;

  localparam logic [IDX_W:0]   SWEEP_END = (IDX_W + 1)'(ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(ENTRIES - 1);
  localparam logic [AGE_BITS-1:0] AGE_ONE = AGE_BITS'(1);

  state_t                 state, state_next;
  logic [IDX_W:0]         cnt;
  logic                   pend;
  logic [IDX_W-1:0]       wb_addr;
  logic [BYTES_W-1:0]     bytes;
  logic [PC_W-1:0]        count;
  logic [PC_W-1:0]        evicted;
  logic [AGE_BITS-1:0]    tgt_age;
  logic [AGE_BITS-1:0]    run_max;
  logic [IDX_W-1:0]       t_addr;
  logic [LENGTH_BITS-1:0] t_len;

  logic [AGE_BITS-1:0]    rd_age;
  logic [LENGTH_BITS-1:0] rd_len;
  logic                   issuing;
  logic                   sweep_end;
  logic                   over_limit;
  logic [ID_CW-1:0]       id_ext;
  logic                   id_ok;
  logic                   touch_add;
  logic [BYTES_W-1:0]     bytes_res;
  logic [PC_W-1:0]        count_res;
  logic [BYT_CW-1:0]      bytes_ext;
  logic [CNT_CW-1:0]      count_ext;
  logic [CNT_CW-1:0]      evict_ext;

  assign rd_age     = rd_data[MEM_W-1 -: AGE_BITS];
  assign rd_len     = rd_data[LENGTH_BITS-1:0];
  assign issuing    = (cnt != SWEEP_END);
  assign sweep_end  = (cnt == SWEEP_END) && !pend;
  assign over_limit = LIM_CW'(limit) < LIM_CW'(bytes);
  assign id_ext     = ID_CW'(read_id);
  assign id_ok      = id_ext < ID_CW'(ENTRIES);

  // A touch of an absent entry with a non-zero length brings the entry in.
  assign touch_add = (state == S_TOUCH) && (rd_len == '0) && (t_len != '0);
  assign bytes_res = bytes + (touch_add ? BYTES_W'(t_len) : '0);
  assign count_res = count + PC_W'(touch_add);

  // Result fields clamp at the widths of the output ports.
  assign bytes_ext = BYT_CW'(bytes_res);
  assign count_ext = CNT_CW'(count_res);
  assign evict_ext = CNT_CW'(evicted);

  always_comb begin
    res.load_needed     = (state == S_TOUCH) && (rd_len == '0);
    res.bytes_in_use    = (bytes_ext > BYT_CW'({BYTES_O_W{1'b1}})) ? '1 :
                          bytes_ext[BYTES_O_W-1:0];
    res.entries_cached  = (count_ext > CNT_CW'({COUNT_O_W{1'b1}})) ? '1 :
                          count_ext[COUNT_O_W-1:0];
    res.entries_evicted = (evict_ext > CNT_CW'({COUNT_O_W{1'b1}})) ? '1 :
                          evict_ext[COUNT_O_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    res_valid  = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = cnt[IDX_W-1:0];
    wr_en      = 1'b0;
    wr_addr    = wb_addr;
    wr_data    = '0;
    unique case (state)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = cnt[IDX_W-1:0];
        if (cnt[IDX_W-1:0] == LAST_IDX) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (op_t'(opcode))
            OP_TOUCH: begin
              if (id_ok) begin
                rd_en      = 1'b1;
                rd_addr    = id_ext[IDX_W-1:0];
                state_next = S_TOUCH;
              end else begin
                state_next = S_DONE;
              end
            end
            OP_BATCH: state_next = S_AGE;
            OP_PURGE: state_next = over_limit ? S_MAX : S_DONE;
            default:  state_next = S_DONE;
          endcase
        end
      end
      S_TOUCH: begin
        if (out_free) begin
          res_valid  = 1'b1;
          wr_en      = 1'b1;
          wr_addr    = t_addr;
          wr_data    = {{AGE_BITS{1'b0}}, touch_add ? t_len : rd_len};
          state_next = S_IDLE;
        end
      end
      S_AGE: begin
        rd_en = issuing;
        if (pend) begin
          wr_en   = 1'b1;
          wr_data = {(rd_age == '1) ? rd_age : rd_age + AGE_ONE, rd_len};
        end
        if (sweep_end) begin
          state_next = S_DONE;
        end
      end
      S_MAX: begin
        rd_en = issuing;
        if (sweep_end) begin
          state_next = (run_max > AGE_ONE) ? S_EVICT : S_DONE;
        end
      end
      S_EVICT: begin
        rd_en = issuing;
        if (pend && (rd_age == tgt_age)) begin
          wr_en = 1'b1;
        end
        if (sweep_end && !(over_limit && (run_max > AGE_ONE))) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          res_valid  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Sweep counter, read pipeline flag and the running totals.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt   <= '0;
      pend  <= 1'b0;
      bytes <= '0;
      count <= '0;
    end else begin
      pend <= rd_en && (state != S_IDLE);
      if (res_valid) begin
        bytes <= bytes_res;
        count <= count_res;
      end
      if ((state == S_EVICT) && pend && (rd_age == tgt_age) && (rd_len != '0)) begin
        bytes <= bytes - BYTES_W'(rd_len);
        count <= count - PC_W'(1);
      end
      if (state == S_IDLE || sweep_end) begin
        cnt <= '0;
      end else if (state == S_CLEAR || (rd_en && state != S_TOUCH)) begin
        cnt <= cnt + (IDX_W + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    wb_addr <= cnt[IDX_W-1:0];
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          evicted <= '0;
          run_max <= '0;
          t_addr  <= id_ext[IDX_W-1:0];
          t_len   <= LENGTH_BITS'(read_length);
        end
      end
      S_MAX, S_EVICT: begin
        if (pend) begin
          if ((state == S_EVICT) && (rd_age == tgt_age)) begin
            if (rd_len != '0) begin
              evicted <= evicted + PC_W'(1);
            end
          end else if (rd_age > run_max) begin
            run_max <= rd_age;
          end
        end
        // At the end of a pass the largest age left becomes the next target.
        if (sweep_end) begin
          tgt_age <= run_max;
          run_max <= '0;
        end
      end
      default: ;
    endcase
  end

endmodule

@@ rtl/abce_checker.sv @@
// ----------------------------------------------------------------------------
// Evictor port checker
// Concurrent checks on the evictor's ports, bound to the top level.
// ----------------------------------------------------------------------------
`include "age_based_cache_evictor_defines.svh"

module abce_port_checker import abce_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 cfg_we,
  input logic [LIMIT_W-1:0]   cfg_wdata,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic [OP_W-1:0]      opcode,
  input logic [ID_W-1:0]      read_id,
  input logic [LEN_IN_W-1:0]  read_length,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic                 load_needed,
  input logic [BYTES_O_W-1:0] bytes_in_use,
  input logic [COUNT_O_W-1:0] entries_cached,
  input logic [COUNT_O_W-1:0] entries_evicted
);

  // A stalled result word must hold.
  `ABCE_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(bytes_in_use) && $stable(entries_cached) && $stable(entries_evicted) && $stable(load_needed), "stalled result word changed")

  // The table is being cleared straight after reset.
  `ABCE_ASSERT_IMPL(a_clear_busy, clk, rst, $fell(rst), !in_ready, "input accepted during the clearing pass")

  // One word at a time: the block is busy in the cycle after an acceptance.
  `ABCE_ASSERT_NEXT(a_one_at_time, clk, rst, in_valid && in_ready, !in_ready, "second word accepted while busy")

  // Only a purge evicts, and a purge never asks for a load.
  `ABCE_ASSERT_IMPL(a_evict_no_load, clk, rst, out_valid && (entries_evicted != '0), !load_needed, "eviction reported together with a load")

endmodule

bind age_based_cache_evictor abce_port_checker u_abce_port_checker (.*);
